// File: design/wmwe_pkg.sv
`timescale 1ns / 1ps

package wmwe_pkg;

  // Field widths
  localparam int SPEED_W     = 16;
  localparam int WEIGHT_W    = 16;
  localparam int EFFORT_W    = 48;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_WEIGHTS = 6;
  localparam int WSEL_W      = 3;

  // Multiplier widths: magnitude squared, then times the weight
  localparam int SQ_W   = 2 * SPEED_W - 1;
  localparam int PROD_W = SQ_W + WEIGHT_W;
  // Product is Q.28, the effort is Q.32
  localparam int FRAC_SHIFT = 4;

  // Default parameter values
  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int MAX_SPEEDS_DEF   = 6;

  // Reset values of the registers
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 3'd6;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd683;
  localparam logic [EFFORT_W-1:0] EFFORT_MAX   = {EFFORT_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_5    = 3'd6;

  // Data handed along the cell chain
  typedef struct packed {
    logic [EFFORT_W-1:0] effort;
    logic [EFFORT_W-1:0] peak;
  } link_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_WGT,
    ST_ACC,
    ST_SCAN,
    ST_LOAD
  } state_t;

endpackage

// File: design/wmwe_cell.sv
`timescale 1ns / 1ps

module wmwe_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  wmwe_pkg::link_t link_i,
  output wmwe_pkg::link_t link_o
);

  logic [wmwe_pkg::EFFORT_W-1:0] effort_r, effort_nxt;
  logic [wmwe_pkg::EFFORT_W-1:0] peak_r, peak_nxt;

  // Take the neighbour's effort on a shift, fold own effort into the running peak
  always_comb begin
    effort_nxt = shift_en ? link_i.effort : effort_r;
    peak_nxt   = (effort_r > link_i.peak) ? effort_r : link_i.peak;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effort_r <= '0;
      peak_r   <= '0;
    end else begin
      effort_r <= effort_nxt;
      peak_r   <= peak_nxt;
    end
  end

  assign link_o.effort = effort_r;
  assign link_o.peak   = peak_r;

endmodule

// File: design/wmwe_term.sv
`timescale 1ns / 1ps

module wmwe_term (
  input  logic                          clk,
  input  logic [wmwe_pkg::SPEED_W-1:0]  mag,
  input  logic [wmwe_pkg::WEIGHT_W-1:0] weight,
  output logic [wmwe_pkg::EFFORT_W-1:0] term
);

  localparam int SAT_LO = wmwe_pkg::EFFORT_W - wmwe_pkg::FRAC_SHIFT;

  logic [wmwe_pkg::SQ_W-1:0]   sq_r, sq_nxt;
  logic [wmwe_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [2*wmwe_pkg::SPEED_W-1:0] sq_full;

  // Square the magnitude, then weight it, one multiplier per stage
  always_comb begin
    sq_full  = mag * mag;
    sq_nxt   = sq_full[wmwe_pkg::SQ_W-1:0];
    prod_nxt = sq_r * weight;
  end

  always_ff @(posedge clk) begin
    sq_r   <= sq_nxt;
    prod_r <= prod_nxt;
  end

  // Move to Q.32 and clamp anything beyond the effort range
  always_comb begin
    if (prod_r[wmwe_pkg::PROD_W-1:SAT_LO] != '0) begin
      term = wmwe_pkg::EFFORT_MAX;
    end else begin
      term = {prod_r[SAT_LO-1:0], {wmwe_pkg::FRAC_SHIFT{1'b0}}};
    end
  end

endmodule

// File: design/windowed_max_weighted_energy.sv
`timescale 1ns / 1ps

// Channel   Direction  Transfer when           Contents
// in_       slave      in_tvalid & in_tready   speed (tdata), frame_end (tlast)
// out_      master     out_tvalid & out_tready max_effort, frame_effort (tdata)
// cfg_      slave      cfg_valid & cfg_ready   register index, write data
//
// A speed without frame_end passes through accept, square, weight and accumulate.
// A speed with frame_end adds a scan and a load step after these; the peak ripples
// through the chain of WINDOW_DEPTH window cells, one cell per cycle.
// Synchronous reset clears the accumulator, position and every window cell.
// The result sits in an output register; a stalled out_ only holds the block
// when a further frame finishes before the earlier result is taken.

module windowed_max_weighted_energy #(
  parameter int WINDOW_DEPTH = wmwe_pkg::WINDOW_DEPTH_DEF,
  parameter int MAX_SPEEDS   = wmwe_pkg::MAX_SPEEDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wmwe_pkg::SPEED_W-1:0]      in_tdata,   // [15:0] speed
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [2*wmwe_pkg::EFFORT_W-1:0]   out_tdata,  // [47:0] max_effort, [95:48] frame_effort
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wmwe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wmwe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int POS_W = $clog2(MAX_SPEEDS + 1);
  localparam int CNT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int EW    = wmwe_pkg::EFFORT_W;

  wmwe_pkg::state_t state_r, state_nxt;

  logic [wmwe_pkg::COUNT_W-1:0]  value_count_r;
  logic [wmwe_pkg::WEIGHT_W-1:0] weight_r [wmwe_pkg::NUM_WEIGHTS];
  logic [wmwe_pkg::COUNT_W-1:0]  eff_count;

  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [EW-1:0]                 acc_r, acc_nxt;
  logic [EW-1:0]                 frame_r, frame_nxt;
  logic [wmwe_pkg::SPEED_W-1:0]  mag_r;
  logic [wmwe_pkg::WEIGHT_W-1:0] wsel_r, wsel;
  logic                          end_r;
  logic                          active_r;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  logic [EW-1:0]                 term;
  logic [EW-1:0]                 add_term;
  logic [EW:0]                   sum;

  logic                          out_valid_r, out_valid_nxt;
  logic [EW-1:0]                 out_max_r, out_frame_r;

  logic                          accept;
  logic                          shift_en;
  logic                          load_out;
  logic [wmwe_pkg::WSEL_W-1:0]   pos_idx;

  wmwe_pkg::link_t chain [WINDOW_DEPTH+1];

  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_count_r <= wmwe_pkg::COUNT_RESET;
      for (int i = 0; i < wmwe_pkg::NUM_WEIGHTS; i++) begin
        weight_r[i] <= wmwe_pkg::WEIGHT_RESET;
      end
    end else if (cfg_valid) begin
      if (cfg_index == wmwe_pkg::REG_VALUE_COUNT) begin
        value_count_r <= cfg_data[wmwe_pkg::COUNT_W-1:0];
      end
      for (int i = 0; i < wmwe_pkg::NUM_WEIGHTS; i++) begin
        if (cfg_index == wmwe_pkg::REG_WEIGHT_0 + wmwe_pkg::CFG_IDX_W'(i)) begin
          weight_r[i] <= cfg_data;
        end
      end
    end
  end

  // Clamp the count into 1..MAX_SPEEDS
  always_comb begin
    if (value_count_r == '0) begin
      eff_count = wmwe_pkg::COUNT_W'(1);
    end else if (value_count_r > wmwe_pkg::COUNT_W'(MAX_SPEEDS)) begin
      eff_count = wmwe_pkg::COUNT_W'(MAX_SPEEDS);
    end else begin
      eff_count = value_count_r;
    end
  end

  // Pick the weight for the current position
  assign pos_idx = wmwe_pkg::WSEL_W'(pos_r);
  always_comb begin
    wsel = '0;
    for (int i = 0; i < wmwe_pkg::NUM_WEIGHTS; i++) begin
      if (pos_idx == wmwe_pkg::WSEL_W'(i)) begin
        wsel = weight_r[i];
      end
    end
  end

  // Latch the item on a transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r    <= in_tdata[wmwe_pkg::SPEED_W-1] ? (-in_tdata) : in_tdata;
      wsel_r   <= wsel;
      end_r    <= in_tlast;
      active_r <= wmwe_pkg::COUNT_W'(pos_r) < eff_count;
    end
  end

  wmwe_term u_term (
    .clk    (clk),
    .mag    (mag_r),
    .weight (wsel_r),
    .term   (term)
  );

  // Saturating accumulate
  always_comb begin
    add_term = active_r ? term : '0;
    sum      = {1'b0, acc_r} + {1'b0, add_term};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wmwe_pkg::ST_IDLE: if (accept) state_nxt = wmwe_pkg::ST_SQR;
      wmwe_pkg::ST_SQR:  state_nxt = wmwe_pkg::ST_WGT;
      wmwe_pkg::ST_WGT:  state_nxt = wmwe_pkg::ST_ACC;
      wmwe_pkg::ST_ACC:  state_nxt = end_r ? wmwe_pkg::ST_SCAN : wmwe_pkg::ST_IDLE;
      wmwe_pkg::ST_SCAN: begin
        if (cnt_r == CNT_W'(WINDOW_DEPTH - 1)) state_nxt = wmwe_pkg::ST_LOAD;
      end
      wmwe_pkg::ST_LOAD: if (!out_valid_r || out_tready) state_nxt = wmwe_pkg::ST_IDLE;
      default:           state_nxt = wmwe_pkg::ST_IDLE;
    endcase
  end

  // State outputs and datapath updates
  always_comb begin
    in_tready = 1'b0;
    shift_en  = 1'b0;
    load_out  = 1'b0;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    frame_nxt = frame_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      wmwe_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (accept && pos_r < POS_W'(MAX_SPEEDS)) pos_nxt = pos_r + POS_W'(1);
      end
      wmwe_pkg::ST_ACC: begin
        cnt_nxt = '0;
        if (end_r) begin
          frame_nxt = sum[EW] ? wmwe_pkg::EFFORT_MAX : sum[EW-1:0];
          shift_en  = 1'b1;
          acc_nxt   = '0;
          pos_nxt   = '0;
        end else begin
          acc_nxt = sum[EW] ? wmwe_pkg::EFFORT_MAX : sum[EW-1:0];
        end
      end
      wmwe_pkg::ST_SCAN: cnt_nxt = cnt_r + CNT_W'(1);
      wmwe_pkg::ST_LOAD: load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // Window: a chain of cells, newest frame enters at the head
  assign chain[0].effort = frame_nxt;
  assign chain[0].peak   = '0;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    wmwe_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .link_i   (chain[k]),
      .link_o   (chain[k+1])
    );
  end

  // Output register: hold until transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (load_out)   out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_max_r   <= chain[WINDOW_DEPTH].peak;
      out_frame_r <= frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wmwe_pkg::ST_IDLE;
      pos_r       <= '0;
      acc_r       <= '0;
      frame_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      frame_r     <= frame_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_frame_r, out_max_r};

endmodule

// File: sim/tb_windowed_max_weighted_energy.sv
`timescale 1ns / 1ps

module tb_windowed_max_weighted_energy;
  import wmwe_pkg::*;

  localparam int DEPTH         = WINDOW_DEPTH_DEF;
  localparam int SPEEDS        = MAX_SPEEDS_DEF;
  // Cycles a frame end spends in the block, plus margin
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 2000;
  localparam int IDLE_PCT      = 31;
  localparam int STEADY_FROM   = 3000;
  localparam int STEADY_TO     = 6000;
  localparam int ITEMS_PER_SET = 136;
  localparam int PRINT_LIMIT   = 40;

  typedef logic [CFG_IDX_W-1:0] reg_index_t;
  // Index just past the last weight register: writes there must do nothing
  localparam reg_index_t REG_UNUSED = REG_WEIGHT_5 + reg_index_t'(1);

  typedef struct {
    logic [SPEED_W-1:0] speed;
    logic               last;
  } speed_item_t;

  typedef struct {
    logic [EFFORT_W-1:0] peak;
    logic [EFFORT_W-1:0] frame;
  } effort_pair_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [SPEED_W-1:0]      in_tdata  = '0;  // [15:0] speed
  logic                    in_tlast  = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [2*EFFORT_W-1:0]   out_tdata;       // [47:0] max_effort, [95:48] frame_effort
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  reg_index_t              cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  // Stimulus and scoreboard
  speed_item_t  speed_q[$];
  effort_pair_t effort_q[$];
  int           speeds_pending = 0;
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           quiet_cycles   = 0;
  logic         in_xfer        = 1'b0;

  // Predictor state and register copy
  logic [COUNT_W-1:0]  count_reg = COUNT_RESET;
  logic [WEIGHT_W-1:0] weight_reg [NUM_WEIGHTS] = '{default: WEIGHT_RESET};
  logic [EFFORT_W-1:0] acc_effort = '0;
  int unsigned         speed_pos  = 0;
  logic [EFFORT_W-1:0] window_effort [DEPTH] = '{default: '0};
  int unsigned         wr_ptr = 0;

  windowed_max_weighted_energy i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Idle at random, except during the steady stretch
  function automatic bit idle_now();
    idle_now = !(cycle_count >= STEADY_FROM && cycle_count < STEADY_TO) &&
               ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic void apply_reg_write(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_VALUE_COUNT) begin
      count_reg = val[COUNT_W-1:0];
    end else if (idx >= REG_WEIGHT_0 && idx <= REG_WEIGHT_5) begin
      weight_reg[idx - REG_WEIGHT_0] = val;
    end
  endfunction

  // Accumulate one weighted squared speed; close the frame on its last speed
  function automatic void predict_speed(logic [SPEED_W-1:0] speed, logic last);
    logic [SPEED_W:0] mag;
    logic [63:0]      term;
    logic [63:0]      sum;
    int unsigned      active;
    effort_pair_t     res;
    mag    = speed[SPEED_W-1] ? (17'h10000 - {1'b0, speed}) : {1'b0, speed};
    active = (count_reg == 0) ? 1 : (count_reg > SPEEDS) ? SPEEDS : count_reg;
    if (speed_pos < active) begin
      term = (64'(mag) * 64'(mag) * 64'(weight_reg[speed_pos])) << FRAC_SHIFT;
      if (term > EFFORT_MAX) term = EFFORT_MAX;
      sum = 64'(acc_effort) + term;
      if (sum > EFFORT_MAX) sum = EFFORT_MAX;
      acc_effort = sum[EFFORT_W-1:0];
    end
    if (speed_pos < SPEEDS) speed_pos++;
    if (last) begin
      window_effort[wr_ptr] = acc_effort;
      wr_ptr    = (wr_ptr + 1) % DEPTH;
      res.frame = acc_effort;
      res.peak  = '0;
      foreach (window_effort[i]) begin
        if (window_effort[i] > res.peak) res.peak = window_effort[i];
      end
      effort_q.insert(effort_q.size(), res);
      acc_effort = '0;
      speed_pos  = 0;
    end
  endfunction

  function automatic void queue_speed(logic [SPEED_W-1:0] speed, logic last);
    speed_item_t it;
    it.speed = speed;
    it.last  = last;
    speed_q.insert(speed_q.size(), it);
    speeds_pending++;
  endfunction

  function automatic logic [SPEED_W-1:0] rand_speed();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       rand_speed = 16'h8000;
      1:       rand_speed = 16'h7FFF;
      2:       rand_speed = 16'h0000;
      3, 4:    rand_speed = 16'($urandom_range(0, 1023)) - 16'd512;
      default: rand_speed = 16'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    case (pick)
      0:       rand_weight = '0;
      1:       rand_weight = '1;
      default: rand_weight = 16'($urandom);
    endcase
  endfunction

  // Mostly whole frames, some short or overlong ones, a little loose noise
  function automatic void queue_random_frames(int unsigned frame_len, int unsigned total);
    int unsigned n;
    int unsigned kind;
    int unsigned len;
    n = 0;
    while (n < total) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) len = frame_len;
      else if (kind < 85) len = $urandom_range(1, frame_len);
      else if (kind < 93) len = frame_len + $urandom_range(1, 3);
      else len = 0;
      if (len == 0) begin
        queue_speed(rand_speed(), 1'($urandom_range(0, 1)));
        n++;
      end else begin
        for (int unsigned k = 1; k <= len; k++) begin
          queue_speed(rand_speed(), k == len);
          if (k <= frame_len || k == len) n++;
        end
      end
    end
  endfunction

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every speed is taken and every result checked, then let the block settle
  task automatic drain_and_settle();
    while (speeds_pending != 0 || effort_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Feed speeds from the queue; hold a speed until its transfer
  always @(negedge clk) begin : drive_speeds
    speed_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_xfer) begin
      if (speed_q.size() != 0 && !idle_now()) begin
        nxt = speed_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.speed;
        in_tlast  <= nxt.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idle_now();
    end
  end

  // Predict on each input transfer, check each result transfer, watch for a hang
  always @(posedge clk) begin : watch_transfers
    effort_pair_t        want;
    logic [EFFORT_W-1:0] got_peak;
    logic [EFFORT_W-1:0] got_frame;
    in_xfer <= in_tvalid && in_tready;
    if (rst_n) begin
      cycle_count++;
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
        quiet_cycles = 0;
      end
      if (in_tvalid && in_tready) begin
        predict_speed(in_tdata, in_tlast);
        speeds_pending--;
        quiet_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        quiet_cycles = 0;
        got_peak  = out_tdata[EFFORT_W-1:0];
        got_frame = out_tdata[2*EFFORT_W-1:EFFORT_W];
        if (effort_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: max %0h frame %0h",
                                    got_peak, got_frame));
        end else begin
          want = effort_q.pop_front();
          if (got_peak !== want.peak)
            report_mismatch($sformatf("max_effort %0h, expected %0h", got_peak, want.peak));
          if (got_frame !== want.frame)
            report_mismatch($sformatf("frame_effort %0h, expected %0h",
                                      got_frame, want.frame));
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : run_test
    logic [COUNT_W-1:0] set_counts [8] = '{3'd1, 3'd3, 3'd6, 3'd7, 3'd0, 3'd2, 3'd4, 3'd5};
    int unsigned        frame_len;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: full frame of extremes, excess speeds, short frame, lone end
    queue_speed(16'h7FFF, 1'b0);
    queue_speed(16'h8000, 1'b0);
    queue_speed(16'h0000, 1'b0);
    queue_speed(16'hFFFF, 1'b0);
    queue_speed(16'h0001, 1'b0);
    queue_speed(16'h0100, 1'b1);
    for (int i = 0; i < 7; i++) queue_speed(16'h7FFF, i == 6);
    queue_speed(16'hC000, 1'b0);
    queue_speed(16'h4000, 1'b1);
    queue_speed(16'h8000, 1'b1);
    drain_and_settle();

    // Count of zero acts as one; full-scale weights saturate each term
    write_reg(REG_VALUE_COUNT, '0);
    for (int r = 0; r < NUM_WEIGHTS; r++) write_reg(reg_index_t'(REG_WEIGHT_0 + r), '1);
    queue_speed(16'h8000, 1'b1);
    queue_speed(16'h8000, 1'b0);
    queue_speed(16'h8000, 1'b1);
    drain_and_settle();

    // Oversized count acts as the maximum; saturate the sum; unused index is ignored
    write_reg(REG_VALUE_COUNT, 16'd7);
    write_reg(REG_WEIGHT_5, '0);
    write_reg(REG_UNUSED, '1);
    for (int i = 0; i < SPEEDS; i++) queue_speed(16'h8000, i == SPEEDS - 1);
    drain_and_settle();

    // Random sets of settings, each with a run of random frames
    foreach (set_counts[s]) begin
      write_reg(REG_VALUE_COUNT, CFG_DATA_W'(set_counts[s]));
      for (int r = 0; r < NUM_WEIGHTS; r++)
        write_reg(reg_index_t'(REG_WEIGHT_0 + r), rand_weight());
      frame_len = (set_counts[s] == 0) ? 1 : (set_counts[s] > SPEEDS) ? SPEEDS : set_counts[s];
      queue_random_frames(frame_len, ITEMS_PER_SET);
      drain_and_settle();
    end

    if (effort_q.size() != 0) report_mismatch("expected results never arrived");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
